// ===== hdl/crc32_packet_receiver_macros.svh =====
// Assertion macros used by the packet receiver controller.
`ifndef CRC32_PACKET_RECEIVER_MACROS_SVH
`define CRC32_PACKET_RECEIVER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CRCRX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define CRCRX_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/crcrx_pkg.sv =====
// Types, constants and the CRC byte update for the packet receiver.
package crcrx_pkg;

	localparam int DATA_W    = 8;
	localparam int TIMEOUT_W = 16;
	localparam int ELAPSED_W = 17;
	localparam int INDEX_W   = 6;
	localparam int ERRCNT_W  = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [DATA_W-1:0]    START_BYTE_RST = 8'h01;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 16'd100;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = '1;

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 1'b1;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_ERR  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RECV,
		ST_CHECK,
		ST_ERR,
		ST_READ,
		ST_LOAD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic tick;
		logic restart;
		logic store;
		logic clear;
		logic err_inc;
		logic rd_en;
		logic load_pkt;
		logic load_err;
	} crcrx_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_start;
		logic timed_out;
		logic count_last;
		logic crc_ok;
		logic rd_last;
		logic out_free;
	} crcrx_sts_t;

	// One byte of the reflected CRC-32, LSB first.
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hdl/crcrx_if.sv =====
// Valid/ready channel interfaces for received items and results.
interface crcrx_in_if
	import crcrx_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [DATA_W-1:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface crcrx_out_if
	import crcrx_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [DATA_W-1:0]   byte_value;
	logic [INDEX_W-1:0]  byte_index;
	logic                last;
	logic [ERRCNT_W-1:0] crc_error_count;

	modport source (output valid, output kind, output byte_value, output byte_index,
		output last, output crc_error_count, input ready);
	modport sink (input valid, input kind, input byte_value, input byte_index,
		input last, input crc_error_count, output ready);
endinterface

// ===== hdl/crcrx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module crcrx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hdl/crcrx_datapath.sv =====
// Packet datapath: config registers, byte store, CRC, timer and result register.
module crcrx_datapath
	import crcrx_pkg::*;
#(
	parameter int PACKET_BYTES = 16,
	parameter int CRC_OFFSET   = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [DATA_W-1:0]     rx_byte,
	input  crcrx_cmd_t            cmd,
	output crcrx_sts_t            sts,
	crcrx_out_if.source           result
);
	localparam int AW = $clog2(PACKET_BYTES);

	logic [DATA_W-1:0]    start_byte_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [AW-1:0]        count_q;
	logic [AW-1:0]        rd_idx_q;
	logic [31:0]          crc_q;
	logic [31:0]          rcrc_q;
	logic [ERRCNT_W-1:0]  err_total_q;

	logic                 out_valid_q;
	logic                 out_kind_q;
	logic [DATA_W-1:0]    out_byte_q;
	logic [INDEX_W-1:0]   out_index_q;
	logic                 out_last_q;
	logic [ERRCNT_W-1:0]  out_count_q;

	logic                 in_field;
	logic [1:0]           lane;
	logic [DATA_W-1:0]    store_byte;
	logic [DATA_W-1:0]    ram_rdata;

	assign in_field = ({1'b0, count_q} >= (AW+1)'(CRC_OFFSET))
		&& ({1'b0, count_q} < (AW+1)'(CRC_OFFSET + 4));
	assign lane       = 2'(count_q - AW'(CRC_OFFSET));
	assign store_byte = in_field ? '0 : rx_byte;

	crcrx_ram #(
		.WIDTH (DATA_W),
		.DEPTH (PACKET_BYTES)
	) u_store (
		.clk   (clk),
		.we    (cmd.store),
		.waddr (count_q),
		.wdata (store_byte),
		.re    (cmd.rd_en),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			timeout_q    <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_BYTE: start_byte_q <= cfg_data[DATA_W-1:0];
				REG_TIMEOUT:    timeout_q    <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
		end else if (cmd.restart) begin
			elapsed_q <= '0;
		end else if (cmd.tick && elapsed_q != ELAPSED_MAX) begin
			elapsed_q <= elapsed_q + 1'b1;
		end
	end

	// Packet accumulation; clear drops back to the idle values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_idx_q <= '0;
			crc_q    <= CRC_INIT;
			rcrc_q   <= '0;
		end else if (cmd.clear) begin
			count_q  <= '0;
			rd_idx_q <= '0;
			crc_q    <= CRC_INIT;
			rcrc_q   <= '0;
		end else begin
			if (cmd.store) begin
				count_q <= count_q + 1'b1;
				crc_q   <= crc_feed(crc_q, store_byte);
				if (in_field) begin
					rcrc_q[lane*8 +: 8] <= rx_byte;
				end
			end
			if (cmd.load_pkt) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_total_q <= '0;
		end else if (cmd.err_inc) begin
			err_total_q <= err_total_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_pkt || cmd.load_err) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pkt) begin
			out_kind_q  <= KIND_BYTE;
			out_byte_q  <= ram_rdata;
			out_index_q <= INDEX_W'(rd_idx_q);
			out_last_q  <= sts.rd_last;
			out_count_q <= err_total_q;
		end else if (cmd.load_err) begin
			out_kind_q  <= KIND_ERR;
			out_byte_q  <= '0;
			out_index_q <= '0;
			out_last_q  <= 1'b1;
			out_count_q <= err_total_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.kind            = out_kind_q;
	assign result.byte_value      = out_byte_q;
	assign result.byte_index      = out_index_q;
	assign result.last            = out_last_q;
	assign result.crc_error_count = out_count_q;

	assign sts.is_start   = (rx_byte == start_byte_q);
	assign sts.timed_out  = (elapsed_q > {1'b0, timeout_q});
	assign sts.count_last = (count_q == AW'(PACKET_BYTES - 1));
	assign sts.crc_ok     = (~crc_q == rcrc_q);
	assign sts.rd_last    = (rd_idx_q == AW'(PACKET_BYTES - 1));
	assign sts.out_free   = !out_valid_q || result.ready;
endmodule

// ===== hdl/crcrx_ctrl.sv =====
// Receiver controller: framing, timeout, CRC verdict and result sequencing.
`include "crc32_packet_receiver_macros.svh"
module crcrx_ctrl
	import crcrx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_cmd,
	output logic       in_ready,
	input  crcrx_sts_t sts,
	output crcrx_cmd_t cmd
);
	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		logic accept;
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		accept   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (accept && in_cmd == CMD_TICK) begin
					cmd.tick = 1'b1;
				end else if (accept && sts.is_start) begin
					cmd.restart = 1'b1;
					cmd.store   = 1'b1;
					state_d     = sts.count_last ? ST_CHECK : ST_RECV;
				end
			end
			ST_RECV: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (accept && in_cmd == CMD_TICK) begin
					cmd.tick = 1'b1;
				end else if (accept && sts.timed_out) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end else if (accept) begin
					cmd.store = 1'b1;
					if (sts.count_last) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				cmd.clear = 1'b1;
				if (sts.crc_ok) begin
					state_d = ST_READ;
				end else begin
					cmd.err_inc = 1'b1;
					state_d     = ST_ERR;
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.load_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				// The read data holds until the result register can take it.
				if (sts.out_free) begin
					cmd.load_pkt = 1'b1;
					state_d      = sts.rd_last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`CRCRX_ASSERT(a_check_one_cycle, (state_q == ST_CHECK) |=> (state_q == ST_READ || state_q == ST_ERR), "verdict state did not resolve in one cycle")
	`CRCRX_ASSERT(a_read_then_load, (state_q == ST_READ) |=> (state_q == ST_LOAD), "store read not followed by result load")
	`CRCRX_NEVER(a_single_load, cmd.load_pkt && cmd.load_err, "packet and error result loaded together")
	`CRCRX_ASSERT(a_load_when_free, (cmd.load_pkt || cmd.load_err) |-> sts.out_free, "result register overwritten before transfer")
endmodule

// ===== hdl/crc32_packet_receiver.sv =====
// A byte or tick transfer is taken only while no packet is being checked or reported.
// The verdict is formed in the cycle after the last packet byte; each good-packet result then
// takes a store read, then a result register load, and a CRC error report is loaded straight
// from the error state; both wait while the output stalls.
// Input is held off from the last packet byte until the final result is loaded.
// Asynchronous reset returns to idle, restores the register defaults and clears the counters.
module crc32_packet_receiver
	import crcrx_pkg::*;
#(
	parameter int PACKET_BYTES = 16,
	parameter int CRC_OFFSET   = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	crcrx_in_if.sink              rx,
	crcrx_out_if.source           result
);
	crcrx_cmd_t cmd;
	crcrx_sts_t sts;

	crcrx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_cmd   (rx.cmd),
		.in_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	crcrx_datapath #(
		.PACKET_BYTES (PACKET_BYTES),
		.CRC_OFFSET   (CRC_OFFSET)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the CRC-32 framed packet receiver.
module tb_top;
	import crcrx_pkg::*;

	localparam int PKT_LEN = 16;
	localparam int CRC_POS = 12;
	localparam logic [31:0] CRC32_REFLECTED = 32'hEDB8_8320;
	localparam int DRAIN_CYCLES = 2 * PKT_LEN + 8;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_BYTES = 16;

	typedef struct {
		logic                kind;
		logic [DATA_W-1:0]   byte_value;
		logic [INDEX_W-1:0]  byte_index;
		logic                last;
		logic [ERRCNT_W-1:0] crc_error_count;
	} rx_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	crcrx_in_if rx();
	crcrx_out_if result();

	crc32_packet_receiver #(
		.PACKET_BYTES(PKT_LEN),
		.CRC_OFFSET(CRC_POS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rx(rx),
		.result(result)
	);

	always #5 clk = ~clk;

	// Shadow copy of the receiver registers and packet state.
	logic [DATA_W-1:0]    start_sel;
	logic [TIMEOUT_W-1:0] timeout_sel;
	bit                   rcv_open;
	int                   rcv_count;
	logic [ELAPSED_W-1:0] ms_since_start;
	logic [DATA_W-1:0]    rcv_bytes [PKT_LEN];
	logic [31:0]          crc_acc;
	logic [31:0]          crc_field;
	logic [ERRCNT_W-1:0]  reject_total;

	rx_result_t rx_results_due [$];
	logic [DATA_W-1:0] frame [PKT_LEN];
	int errors = 0;
	int bytes_sent = 0;
	int quiet_cycles = 0;
	bit src_idle_en;
	bit snk_idle_en;
	bit hold_off_req = 1'b0;

	function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		logic fb;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			fb = c[0] ^ b[k];
			c = {1'b0, c[31:1]};
			if (fb)
				c = c ^ CRC32_REFLECTED;
		end
		return c;
	endfunction

	task automatic reset_capture();
		rcv_open = 1'b0;
		rcv_count = 0;
		crc_acc = '1;
		crc_field = '0;
	endtask

	// The CRC field is collected little-endian and enters the CRC as zeros.
	task automatic capture_byte(logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] v;
		v = b;
		if (rcv_count >= CRC_POS && rcv_count < CRC_POS + 4) begin
			crc_field |= {24'd0, b} << (8 * (rcv_count - CRC_POS));
			v = '0;
		end
		rcv_bytes[rcv_count] = v;
		crc_acc = crc32_byte(crc_acc, v);
		rcv_count++;
	endtask

	task automatic judge_rx_item(logic cmd, logic [DATA_W-1:0] b);
		rx_result_t r;
		bit crc_ok;
		if (cmd == CMD_TICK) begin
			if (ms_since_start != ELAPSED_MAX)
				ms_since_start++;
			return;
		end
		if (!rcv_open) begin
			if (b != start_sel)
				return;
			reset_capture();
			rcv_open = 1'b1;
			ms_since_start = '0;
			capture_byte(b);
		end else if (ms_since_start > timeout_sel) begin
			reset_capture();
			return;
		end else begin
			capture_byte(b);
		end
		if (rcv_count < PKT_LEN)
			return;
		crc_ok = (~crc_acc == crc_field);
		reset_capture();
		if (crc_ok) begin
			for (int i = 0; i < PKT_LEN; i++) begin
				r.kind = KIND_BYTE;
				r.byte_value = rcv_bytes[i];
				r.byte_index = INDEX_W'(i);
				r.last = (i == PKT_LEN - 1);
				r.crc_error_count = reject_total;
				rx_results_due.push_back(r);
			end
		end else begin
			reject_total++;
			r.kind = KIND_ERR;
			r.byte_value = '0;
			r.byte_index = '0;
			r.last = 1'b1;
			r.crc_error_count = reject_total;
			rx_results_due.push_back(r);
		end
	endtask

	// Called right after a rising edge; returns right after the edge of the transfer.
	task automatic send_item(logic cmd, logic [DATA_W-1:0] b);
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			rx.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.cmd <= cmd;
		rx.rx_byte <= b;
		do @(posedge clk); while (!rx.ready);
		judge_rx_item(cmd, b);
		if (cmd == CMD_BYTE)
			bytes_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_START_BYTE)
			start_sel = val[DATA_W-1:0];
		else
			timeout_sel = val;
	endtask

	// Closes any open packet with filler bytes, then lets the block drain completely.
	task automatic settle();
		while (rcv_open)
			send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
		rx.valid <= 1'b0;
		while (rx_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [DATA_W-1:0] sb, logic [TIMEOUT_W-1:0] tmo);
		settle();
		write_reg(REG_START_BYTE, CFG_DATA_W'(sb));
		write_reg(REG_TIMEOUT, tmo);
	endtask

	task automatic fill_frame();
		frame[0] = start_sel;
		for (int i = 1; i < PKT_LEN; i++)
			frame[i] = 8'($urandom_range(0, 255));
	endtask

	task automatic seal_frame(bit corrupt);
		logic [31:0] c;
		c = '1;
		for (int i = 0; i < PKT_LEN; i++)
			c = crc32_byte(c, (i >= CRC_POS && i < CRC_POS + 4) ? 8'h00 : frame[i]);
		c = ~c;
		if (corrupt)
			c = c ^ (32'h1 << $urandom_range(0, 31));
		for (int k = 0; k < 4; k++)
			frame[CRC_POS + k] = c[8*k +: 8];
	endtask

	// Sends the frame, scattering at most tick_budget ticks between its bytes.
	task automatic send_frame(int tick_budget);
		int n;
		for (int i = 0; i < PKT_LEN; i++) begin
			send_item(CMD_BYTE, frame[i]);
			if (i < PKT_LEN - 1 && tick_budget > 0 && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, (tick_budget < 3) ? tick_budget : 3);
				tick_budget -= n;
				repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic send_good_frame(int tick_budget);
		fill_frame();
		seal_frame(1'b0);
		send_frame(tick_budget);
	endtask

	task automatic test_reset_values();
		send_item(CMD_BYTE, 8'h02);
		send_item(CMD_TICK, 8'hFF);
		send_good_frame(4);
	endtask

	task automatic test_crc_mismatch();
		fill_frame();
		seal_frame(1'b1);
		send_frame(5);
		fill_frame();
		seal_frame(1'b1);
		send_frame(0);
		send_good_frame(0);
	endtask

	task automatic test_start_byte_as_data();
		fill_frame();
		frame[1] = start_sel;
		frame[2] = 8'h00;
		frame[3] = 8'hFF;
		frame[PKT_LEN - 1] = start_sel;
		seal_frame(1'b0);
		send_frame(0);
	endtask

	task automatic test_register_extremes();
		configure(8'h00, 16'd0);
		send_good_frame(0);
		// With a zero timeout a single tick after the start byte is enough to abort.
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_BYTE, 8'h5A);
		configure(8'hFF, 16'hFFFF);
		send_good_frame(8);
	endtask

	task automatic test_timeout_boundary();
		configure(8'h3C, 16'd3);
		send_item(CMD_BYTE, 8'h3C);
		repeat (3) send_item(CMD_TICK, 8'h00);
		send_item(CMD_BYTE, 8'hA5);
		send_item(CMD_TICK, 8'hFF);
		send_item(CMD_BYTE, 8'h96);
		send_good_frame(3);
	endtask

	task automatic test_output_backpressure();
		settle();
		hold_off_req = 1'b1;
		repeat (2) send_good_frame(0);
	endtask

	task automatic random_episode();
		int k;
		logic [DATA_W-1:0] b;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: send_good_frame((timeout_sel < 8) ? int'(timeout_sel) : 8);
			6, 7: begin
				fill_frame();
				seal_frame(1'b1);
				send_frame(0);
			end
			8: begin
				if (timeout_sel <= 40) begin
					fill_frame();
					seal_frame(1'b0);
					k = $urandom_range(1, PKT_LEN - 1);
					for (int i = 0; i < k; i++)
						send_item(CMD_BYTE, frame[i]);
					repeat (int'(timeout_sel) + 1 + $urandom_range(0, 2))
						send_item(CMD_TICK, 8'($urandom_range(0, 255)));
					send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
				end else begin
					send_good_frame(8);
				end
			end
			default: begin
				repeat ($urandom_range(1, 4)) begin
					b = 8'($urandom_range(0, 255));
					if (b == start_sel)
						b = ~b;
					if ($urandom_range(0, 2) == 0)
						send_item(CMD_TICK, b);
					else
						send_item(CMD_BYTE, b);
				end
			end
		endcase
	endtask

	task automatic test_random_traffic();
		int first;
		logic [TIMEOUT_W-1:0] tmo;
		first = bytes_sent;
		while (bytes_sent - first < RANDOM_BYTES) begin
			case ($urandom_range(0, 5))
				0: tmo = '0;
				1: tmo = '1;
				default: tmo = 16'($urandom_range(1, 20));
			endcase
			configure(8'($urandom_range(0, 255)), tmo);
			src_idle_en = ($urandom_range(0, 3) != 0);
			snk_idle_en = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 5)) random_episode();
		end
	endtask

	task automatic test_unthrottled_finish();
		settle();
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		send_good_frame(0);
		fill_frame();
		seal_frame(1'b1);
		send_frame(0);
		send_good_frame(0);
	endtask

	initial begin
		rx.valid <= 1'b0;
		rx.cmd <= CMD_BYTE;
		rx.rx_byte <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_START_BYTE;
		cfg_data <= '0;
		arst_n <= 1'b0;
		start_sel = START_BYTE_RST;
		timeout_sel = TIMEOUT_RST;
		ms_since_start = '0;
		reject_total = '0;
		reset_capture();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_crc_mismatch();
		test_start_byte_as_data();
		test_register_extremes();
		test_timeout_boundary();
		test_output_backpressure();
		test_random_traffic();
		test_unthrottled_finish();
		settle();

		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// Result sink: random stalls, plus one long hold-off on request.
	initial begin
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				result.ready <= 1'b1;
				hold_off_req = 1'b0;
			end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				result.ready <= 1'b1;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		rx_result_t want;
		if (arst_n && result.valid && result.ready) begin
			if (rx_results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got kind %0d byte 0x%0h index %0d",
					$time, result.kind, result.byte_value, result.byte_index);
				errors++;
			end else begin
				want = rx_results_due.pop_front();
				check_field("kind", 32'(want.kind), 32'(result.kind));
				check_field("byte_value", 32'(want.byte_value), 32'(result.byte_value));
				check_field("byte_index", 32'(want.byte_index), 32'(result.byte_index));
				check_field("last", 32'(want.last), 32'(result.last));
				check_field("crc_error_count", 32'(want.crc_error_count),
					32'(result.crc_error_count));
			end
		end
	end

	// Ends the run if neither channel sees a transfer for too long.
	always @(posedge clk) begin
		if (!arst_n || (rx.valid && rx.ready) || (result.valid && result.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

endmodule

// ===== crc32_packet_receiver.f =====
+incdir+hdl
hdl/crcrx_pkg.sv
hdl/crcrx_if.sv
hdl/crcrx_ram.sv
hdl/crcrx_datapath.sv
hdl/crcrx_ctrl.sv
hdl/crc32_packet_receiver.sv
verif/tb_top.sv
